// File: hdl/five_point_blur_filter_defines.svh
// Assertion macros shared by the five-point blur filter RTL.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef FIVE_POINT_BLUR_FILTER_DEFINES_SVH
`define FIVE_POINT_BLUR_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBF_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/fbf_pkg.sv
// Types, register codes and constants for the five-point blur filter.
// No dependencies; the RTL modules reference it by scoped names.
`default_nettype none

package fbf_pkg;

	// Width of position and size arithmetic (sizes up to 8192 plus margin).
	localparam int POS_W = 14;
	localparam int CFG_W = 11;
	localparam int BPP_W = 4;
	localparam int PIX_W = 8;
	localparam int OPOS_W = 10;
	localparam int MIN_SIZE = 3;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_BOX_LEFT     = 3'd2,
		REG_BOX_RIGHT    = 3'd3,
		REG_BOX_TOP      = 3'd4,
		REG_BOX_BOTTOM   = 3'd5,
		REG_IN_BPP       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] frame_width;
		logic [CFG_W-1:0] frame_height;
		logic [CFG_W-1:0] box_left;
		logic [CFG_W-1:0] box_right;
		logic [CFG_W-1:0] box_top;
		logic [CFG_W-1:0] box_bottom;
		logic [BPP_W-1:0] in_bits_per_pixel;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} in_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_out;
		logic [OPOS_W-1:0] out_row;
		logic [OPOS_W-1:0] out_col;
		logic              frame_last;
	} out_beat_t;

	// The five neighbours of one output pixel.
	typedef struct packed {
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] down;
		logic [PIX_W-1:0] centre;
	} taps_t;

	// Exact floor(m / 3) for m below 8192: (m * 2731) >> 13.
	localparam int DIV3_MUL = 2731;
	localparam int DIV3_SHIFT = 13;

	// Saturate a configured frame size into [MIN_SIZE, maxv].
	function automatic logic [POS_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [POS_W-1:0] maxv);
		logic [POS_W-1:0] ve;
		ve = POS_W'(v);
		if (ve < POS_W'(MIN_SIZE)) begin
			return POS_W'(MIN_SIZE);
		end else if (ve > maxv) begin
			return maxv;
		end
		return ve;
	endfunction

endpackage

`default_nettype wire

// File: hdl/fbf_line_buf.sv
// Two line buffers (rows r-1 and r-2) with registered reads and a clearing pass.
// Depends on fbf_pkg for the pixel width.
`default_nettype none

module fbf_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	input  wire logic [fbf_pkg::PIX_W-1:0] wr_pixel,
	input  wire logic                     wr2_en,
	input  wire logic [AW-1:0]            wr2_addr,
	input  wire logic [fbf_pkg::PIX_W-1:0] wr2_data,
	output logic      [fbf_pkg::PIX_W-1:0] up_s1,
	output logic      [fbf_pkg::PIX_W-1:0] up2_s1,
	output logic                          busy
);

	logic [fbf_pkg::PIX_W-1:0] prev_mem [DEPTH];
	logic [fbf_pkg::PIX_W-1:0] prev2_mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;

	assign busy = clr_busy_q;

	// Clearing pass after reset: one entry of each buffer per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Row r-1: read old value and write the new pixel at the same address.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			prev_mem[clr_addr_q] <= '0;
		end else if (rd_en) begin
			up_s1 <= prev_mem[rd_addr];
			prev_mem[rd_addr] <= wr_pixel;
		end
	end

	// Row r-2: written one stage later, so forward a write that lands on the read.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			prev2_mem[clr_addr_q] <= '0;
		end else begin
			if (rd_en) begin
				if (wr2_en && wr2_addr == rd_addr) begin
					up2_s1 <= wr2_data;
				end else begin
					up2_s1 <= prev2_mem[rd_addr];
				end
			end
			if (wr2_en) begin
				prev2_mem[wr2_addr] <= wr2_data;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/fbf_pos_ctr.sv
// Raster position counters with frame restart and wrap on size changes.
// Depends on fbf_pkg for the position width.
`default_nettype none

module fbf_pos_ctr #(
	parameter int CW = 10,
	parameter int RW = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic                      frame_start,
	input  wire logic [fbf_pkg::POS_W-1:0] w_lim,
	input  wire logic [fbf_pkg::POS_W-1:0] h_lim,
	output logic      [CW-1:0]             col,
	output logic      [RW-1:0]             row
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [fbf_pkg::POS_W-1:0] col_e, row_e, row_w, c_cur, r_cur, c_nxt, r_nxt;
	logic [fbf_pkg::POS_W-1:0] col_d, row_d;

	// Position of the beat at the input, then the position after it.
	always_comb begin
		col_e = frame_start ? '0 : fbf_pkg::POS_W'(col_q);
		row_e = frame_start ? '0 : fbf_pkg::POS_W'(row_q);
		if (col_e >= w_lim) begin
			c_cur = '0;
			row_w = row_e + 1'b1;
		end else begin
			c_cur = col_e;
			row_w = row_e;
		end
		r_cur = (row_w >= h_lim) ? '0 : row_w;
		c_nxt = c_cur + 1'b1;
		r_nxt = r_cur + 1'b1;
		if (c_nxt >= w_lim) begin
			col_d = '0;
			row_d = (r_nxt >= h_lim) ? '0 : r_nxt;
		end else begin
			col_d = c_nxt;
			row_d = r_cur;
		end
	end

	assign col = c_cur[CW-1:0];
	assign row = r_cur[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_d[CW-1:0];
			row_q <= row_d[RW-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hdl/fbf_kernel.sv
// Five-point weighted blur with box masking, rounding and saturation.
// Depends on fbf_pkg for the tap, configuration and result types.
`default_nettype none

module fbf_kernel (
	input  wire fbf_pkg::taps_t            taps,
	input  wire fbf_pkg::cfg_t             cfg,
	input  wire logic [fbf_pkg::POS_W-1:0] row,
	input  wire logic [fbf_pkg::POS_W-1:0] col,
	input  wire logic [fbf_pkg::POS_W-1:0] w_lim,
	input  wire logic [fbf_pkg::POS_W-1:0] h_lim,
	output logic                           res_valid,
	output fbf_pkg::out_beat_t             res
);

	logic [10:0] sum;
	logic [12:0] scaled;
	logic [11:0] half;
	logic [23:0] prod;
	logic [9:0]  quot;
	logic [fbf_pkg::PIX_W-1:0] blur;
	logic [fbf_pkg::POS_W-1:0] orow, ocol;
	logic box_empty, in_box;

	// Weighted sum, scaled for one-bit input, then round(x/6) = floor((x+3)/2 / 3).
	always_comb begin
		sum = 11'(taps.left) + 11'(taps.right) + 11'(taps.up) + 11'(taps.down)
			+ {2'b00, taps.centre, 1'b0};
		scaled = (cfg.in_bits_per_pixel < 4'd2) ? (13'(sum) + {1'b0, sum, 1'b0})
			: 13'(sum);
		half = 12'((14'(scaled) + 14'd3) >> 1);
		prod = 24'(half) * 24'(fbf_pkg::DIV3_MUL);
		quot = prod[fbf_pkg::DIV3_SHIFT +: 10];
		blur = (quot > 10'd255) ? 8'd255 : quot[7:0];
	end

	// Box test on the output position, shrunk by one on every side.
	always_comb begin
		orow = row - 1'b1;
		ocol = col - 1'b1;
		box_empty = (cfg.box_left >= cfg.box_right) || (cfg.box_top >= cfg.box_bottom);
		in_box = (orow >= fbf_pkg::POS_W'(cfg.box_top) + 1'b1)
			&& (orow + 2'd2 <= fbf_pkg::POS_W'(cfg.box_bottom))
			&& (ocol >= fbf_pkg::POS_W'(cfg.box_left) + 1'b1)
			&& (ocol + 2'd2 <= fbf_pkg::POS_W'(cfg.box_right));
	end

	// Result beat; none for the first row or column.
	always_comb begin
		res_valid = (row != '0) && (col != '0);
		if (box_empty) begin
			res.pixel_out = taps.centre;
		end else if (in_box) begin
			res.pixel_out = blur;
		end else begin
			res.pixel_out = '0;
		end
		res.out_row = orow[fbf_pkg::OPOS_W-1:0];
		res.out_col = ocol[fbf_pkg::OPOS_W-1:0];
		res.frame_last = (orow == h_lim - 2'd2) && (ocol == w_lim - 2'd2);
	end

endmodule

`default_nettype wire

// File: hdl/five_point_blur_filter.sv
// Path: an accepted beat goes to stage 1, then its completed result to the output register.
// Throughput: one pixel per cycle unless stalled; buffers: a read and a write per cycle.
// Reset: arst_n clears counters, window and config to defaults, then a clearing
// pass zeroes all MAX_WIDTH entries of both line buffers; in_ready stays low meanwhile.
// Top level of the five-point blur filter; depends on fbf_pkg, fbf_line_buf,
// fbf_pos_ctr, fbf_kernel and five_point_blur_filter_defines.svh.
`default_nettype none
`include "five_point_blur_filter_defines.svh"

module five_point_blur_filter #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [fbf_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire fbf_pkg::in_beat_t         in_beat,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output fbf_pkg::out_beat_t             out_beat
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	fbf_pkg::cfg_t cfg_q;
	logic [fbf_pkg::POS_W-1:0] w_lim, h_lim;

	logic in_acc, s1_adv, clr_busy;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;

	logic                      valid_s1;
	logic [fbf_pkg::PIX_W-1:0] pix_s1;
	logic [CW-1:0]             c_s1;
	logic [RW-1:0]             r_s1;
	logic [fbf_pkg::PIX_W-1:0] up_s1, up2_s1;

	// Window: left of current row, left and centre of row above, centre two rows up.
	logic [fbf_pkg::PIX_W-1:0] win_down_q, win_left_q, win_centre_q, win_up_q;

	fbf_pkg::taps_t     taps;
	logic               res_valid;
	fbf_pkg::out_beat_t res;
	logic               out_valid_q;
	fbf_pkg::out_beat_t out_beat_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= 11'd1024;
			cfg_q.frame_height <= 11'd1024;
			cfg_q.box_left <= '0;
			cfg_q.box_right <= '0;
			cfg_q.box_top <= '0;
			cfg_q.box_bottom <= '0;
			cfg_q.in_bits_per_pixel <= 4'd1;
		end else if (cfg_we) begin
			unique case (fbf_pkg::cfg_reg_t'(cfg_index))
				fbf_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width <= cfg_wdata;
				fbf_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata;
				fbf_pkg::REG_BOX_LEFT:     cfg_q.box_left <= cfg_wdata;
				fbf_pkg::REG_BOX_RIGHT:    cfg_q.box_right <= cfg_wdata;
				fbf_pkg::REG_BOX_TOP:      cfg_q.box_top <= cfg_wdata;
				fbf_pkg::REG_BOX_BOTTOM:   cfg_q.box_bottom <= cfg_wdata;
				fbf_pkg::REG_IN_BPP:       cfg_q.in_bits_per_pixel <= cfg_wdata[fbf_pkg::BPP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign w_lim = fbf_pkg::clamp_size(cfg_q.frame_width, fbf_pkg::POS_W'(MAX_WIDTH));
	assign h_lim = fbf_pkg::clamp_size(cfg_q.frame_height, fbf_pkg::POS_W'(MAX_HEIGHT));

	// Handshake: stage 1 moves on when the output register is free or draining.
	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clr_busy && (!valid_s1 || s1_adv);
	assign in_acc = in_valid && in_ready;

	fbf_pos_ctr #(
		.CW(CW),
		.RW(RW)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.advance(in_acc),
		.frame_start(in_beat.frame_start),
		.w_lim(w_lim),
		.h_lim(h_lim),
		.col(col_cur),
		.row(row_cur)
	);

	fbf_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_lines (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_acc),
		.rd_addr(col_cur),
		.wr_pixel(in_beat.pixel_in),
		.wr2_en(s1_adv),
		.wr2_addr(c_s1),
		.wr2_data(up_s1),
		.up_s1(up_s1),
		.up2_s1(up2_s1),
		.busy(clr_busy)
	);

	// Stage 1: accepted beat and its position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= in_beat.pixel_in;
			c_s1 <= col_cur;
			r_s1 <= row_cur;
		end
	end

	// Window shifts as each beat leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_down_q <= '0;
			win_left_q <= '0;
			win_centre_q <= '0;
			win_up_q <= '0;
		end else if (s1_adv) begin
			win_left_q <= win_centre_q;
			win_centre_q <= up_s1;
			win_up_q <= up2_s1;
			win_down_q <= pix_s1;
		end
	end

	always_comb begin
		taps.left = win_left_q;
		taps.right = up_s1;
		taps.up = win_up_q;
		taps.down = win_down_q;
		taps.centre = win_centre_q;
	end

	fbf_kernel u_kernel (
		.taps(taps),
		.cfg(cfg_q),
		.row(fbf_pkg::POS_W'(r_s1)),
		.col(fbf_pkg::POS_W'(c_s1)),
		.w_lim(w_lim),
		.h_lim(h_lim),
		.res_valid(res_valid),
		.res(res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_beat_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat = out_beat_q;

	`FBF_ASSERT_NOW(a_no_accept_while_clearing, clr_busy, !in_ready,
		"input accepted during line buffer clearing")
	`FBF_ASSERT_NEXT(a_result_reaches_output, s1_adv && res_valid, out_valid,
		"result beat from stage 1 did not reach the output register")
	`FBF_ASSERT_NEXT(a_stage1_holds, valid_s1 && !s1_adv,
		valid_s1 && $stable(c_s1) && $stable(pix_s1),
		"stalled stage 1 beat changed")

endmodule

`default_nettype wire
